// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Constants, microcode types and the control store of the continued fraction
// expansion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int IN_WIDTH        = 32;
	localparam int COEF_WIDTH      = 33;
	localparam int MAX_RESULTS     = 48;
	localparam int CNT_WIDTH       = $clog2(MAX_RESULTS);
	localparam int STEP_WIDTH      = 3;

	typedef logic [STEP_WIDTH-1:0] step_t;

	// Microprogram addresses
	localparam step_t S_IDLE  = 3'd0;
	localparam step_t S_CHECK = 3'd1;
	localparam step_t S_DIVGO = 3'd2;
	localparam step_t S_WAIT  = 3'd3;
	localparam step_t S_EMIT  = 3'd4;
	localparam step_t S_ERR   = 3'd5;

	// Datapath operation of a step
	typedef enum logic [2:0] {
		OP_NOP      = 3'd0,
		OP_LOAD     = 3'd1,
		OP_DIV_GO   = 3'd2,
		OP_EMIT     = 3'd3,
		OP_EMIT_ERR = 3'd4
	} op_t;

	// Jump condition of a step
	typedef enum logic [2:0] {
		JC_ALWAYS   = 3'd0,
		JC_START    = 3'd1,
		JC_DEN_ZERO = 3'd2,
		JC_DIV_DONE = 3'd3,
		JC_LAST     = 3'd4
	} jc_t;

	typedef struct packed {
		op_t   op;
		jc_t   jc;
		step_t jmp;   // taken when jc holds
		step_t nxt;   // taken otherwise
	} ctrl_t;

	// Control store: one word per step.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		unique case (step)
			S_IDLE:  w = '{op: OP_LOAD,     jc: JC_START,    jmp: S_CHECK, nxt: S_IDLE};
			S_CHECK: w = '{op: OP_NOP,      jc: JC_DEN_ZERO, jmp: S_ERR,   nxt: S_DIVGO};
			S_DIVGO: w = '{op: OP_DIV_GO,   jc: JC_ALWAYS,   jmp: S_WAIT,  nxt: S_WAIT};
			S_WAIT:  w = '{op: OP_NOP,      jc: JC_DIV_DONE, jmp: S_EMIT,  nxt: S_WAIT};
			S_EMIT:  w = '{op: OP_EMIT,     jc: JC_LAST,     jmp: S_IDLE,  nxt: S_DIVGO};
			S_ERR:   w = '{op: OP_EMIT_ERR, jc: JC_ALWAYS,   jmp: S_IDLE,  nxt: S_IDLE};
			default: w = '{op: OP_NOP,      jc: JC_ALWAYS,   jmp: S_IDLE,  nxt: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: src/rcf_divider.sv
// ----------------------------------------------------------------------------
// rcf_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_divider
	import rcf_pkg::*;
#(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);

	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          ge;
	logic [W-1:0]  rem_nxt;

	assign shifted = {rem_q, quo_q[W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};
	assign rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: src/rational_continued_fraction.sv
// ----------------------------------------------------------------------------
// rational_continued_fraction
// Simple continued fraction expansion of a signed rational, microcoded.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive numerator, denominator and negative, raise start. The
//   transaction is taken on a rising edge with start high and busy low.
//   busy stays high until the last coefficient has been issued.
//   Output: every coefficient is shown for one cycle with strobe high; the
//   final one of a transaction has last high. The receiver cannot stall, so
//   results must be taken on the cycle they appear.
//   A zero denominator yields one result: error = 1, last = 1, coefficient 0.
// Sequence:
//   Each coefficient costs one pass of the shared bit-serial divider plus
//   three microcode steps (issue, wait exit, emit). A full expansion has
//   at most 48 coefficients; a zero denominator goes from the check step
//   straight to the error result.
//   busy drops on the cycle the last result is shown.
// Reset:
//   arst_n clears the step register and the strobe; the block comes up idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_continued_fraction
	import rcf_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [IN_WIDTH-1:0]   numerator,
	input  wire logic [IN_WIDTH-1:0]   denominator,
	input  wire logic                  negative,
	output logic                       strobe,
	output logic signed [COEF_WIDTH-1:0] coefficient,
	output logic                       last,
	output logic                       error
);

	localparam int W = VALUE_WIDTH;

	// Sequencer
	step_t step_q;
	ctrl_t cw;
	logic  jc_true;

	// Datapath: dvd_q / dvs_q are the Euclidean pair (p, q) of the expansion.
	// On the first pass they hold numerator / denominator.
	logic [W-1:0]         dvd_q;
	logic [W-1:0]         dvs_q;
	logic                 neg_q;
	logic [CNT_WIDTH-1:0] count_q;

	logic                 div_go;
	logic                 div_busy;
	logic [W-1:0]         quot;
	logic [W-1:0]         rem;

	// Emit-time values
	logic                  first;
	logic                  neg_first;
	logic [COEF_WIDTH-1:0] qext;
	logic [COEF_WIDTH-1:0] coef_w;
	logic [W-1:0]          q_next;
	logic                  last_w;

	// Output registers
	logic                  strobe_q;
	logic [COEF_WIDTH-1:0] coef_q;
	logic                  last_q;
	logic                  error_q;

	assign cw = ucode(step_q);

	always_comb begin
		unique case (cw.jc)
			JC_ALWAYS:   jc_true = 1'b1;
			JC_START:    jc_true = start;
			JC_DEN_ZERO: jc_true = (dvs_q == '0);
			JC_DIV_DONE: jc_true = !div_busy;
			JC_LAST:     jc_true = last_w;
			default:     jc_true = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= jc_true ? cw.jmp : cw.nxt;
		end
	end

	assign busy = (step_q != S_IDLE);

	assign div_go = (cw.op == OP_DIV_GO);

	rcf_divider #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.busy     (div_busy),
		.quotient (quot),
		.remainder(rem)
	);

	// Floor handling only on the leading coefficient of a negative value:
	// with a remainder, a0 = -(Q+1) = ~Q and the fraction becomes den - rem;
	// without one, a0 = -Q and the expansion ends.
	always_comb begin
		first     = (count_q == '0);
		neg_first = first && neg_q;
		qext      = COEF_WIDTH'(quot);
		if (neg_first) begin
			if (rem != '0) begin
				coef_w = ~qext;
				q_next = dvs_q - rem;
			end else begin
				coef_w = ~qext + 1'b1;
				q_next = '0;
			end
		end else begin
			coef_w = qext;
			q_next = rem;
		end
		last_w = (q_next == '0) || (count_q == CNT_WIDTH'(MAX_RESULTS - 1));
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (start) begin
					dvd_q   <= numerator[W-1:0];
					dvs_q   <= denominator[W-1:0];
					neg_q   <= negative;
					count_q <= '0;
				end
			end
			OP_EMIT: begin
				// Reciprocal swap: p <- q, q <- q_next (remainder, floor-adjusted on a negative a0)
				dvd_q   <= dvs_q;
				dvs_q   <= q_next;
				count_q <= count_q + 1'b1;
			end
			OP_NOP, OP_DIV_GO, OP_EMIT_ERR: begin
			end
			default: begin
			end
		endcase
	end

	// Result transaction register: strobe is a one-cycle pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cw.op == OP_EMIT) || (cw.op == OP_EMIT_ERR);
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT) begin
			coef_q  <= coef_w;
			last_q  <= last_w;
			error_q <= 1'b0;
		end else if (cw.op == OP_EMIT_ERR) begin
			coef_q  <= '0;
			last_q  <= 1'b1;
			error_q <= 1'b1;
		end
	end

	assign strobe      = strobe_q;
	assign coefficient = coef_q;
	assign last        = last_q;
	assign error       = error_q;

endmodule

`default_nettype wire

// File: src/rcf_checker.sv
// ----------------------------------------------------------------------------
// rcf_checker
// Port-level checks of the continued fraction block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rcf_checker
	import rcf_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   strobe,
	input wire logic [COEF_WIDTH-1:0]  coefficient,
	input wire logic                   last,
	input wire logic                   error
);

	`ASSERT_IMPL(a_err_last, strobe && error, last, "error result not marked last")
	`ASSERT_IMPL(a_err_zero, strobe && error, coefficient == '0, "error result with nonzero coefficient")
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accepted transaction")
	`ASSERT_NEXT(a_last_gap, strobe && last, !strobe, "result right after last")
	`ASSERT_NEXT(a_more_busy, strobe && !last, busy, "idle while expansion unfinished")

endmodule

bind rational_continued_fraction rcf_checker u_rcf_checker (.*);

`default_nettype wire
